[rtl/confusion_matrix_metrics_core_macros.svh]
// assertion helpers
`ifndef CONFUSION_MATRIX_METRICS_CORE_MACROS_SVH
`define CONFUSION_MATRIX_METRICS_CORE_MACROS_SVH
`define CMM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CMM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[rtl/cmm_pkg.sv]
`default_nettype none
package cmm_pkg;
   localparam int Classes = 16;
   localparam int Rows = Classes + 1;
   localparam int Cells = Rows * Classes;
   localparam int CellBits = $clog2(Cells);
   localparam int CountBits = 32;
   localparam int QBits = 17;

   localparam logic [1:0] ModeRecord = 2'd0;
   localparam logic [1:0] ModeAdd = 2'd1;
   localparam logic [1:0] ModeReport = 2'd2;
   localparam logic [1:0] ModeUnused = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [3:0] true_class;
      logic true_unknown;
      logic [3:0] predicted_class;
      logic predicted_present;
      logic [31:0] add_count;
      logic [3:0] report_class;
   } req_type;

   typedef struct packed {
      logic [31:0] true_pos;
      logic [31:0] false_pos;
      logic [31:0] true_neg;
      logic [31:0] false_neg;
      logic [16:0] precision_q16;
      logic [16:0] recall_q16;
      logic [16:0] fpr_q16;
      logic [16:0] fscore_q16;
      logic [16:0] auc_q16;
      logic [4:0] valid_mask;
      logic error;
   } rsp_type;

   // classified command passed from front to back
   typedef struct packed {
      logic is_update;
      logic is_report;
      logic error;
      logic [CellBits-1:0] cell_idx;
      logic [31:0] inc;
      logic [3:0] rcls;
   } cmd_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction
endpackage
`default_nettype wire

[rtl/confusion_matrix_metrics_core.sv]
`default_nettype none
// Confusion matrix counter with per-class metric report. One result word per request
// word. After reset the block clears its 272-cell store, one cell a cycle, before taking
// requests. Record and add words go through read, write and respond; a report walks all
// 272 cells and then runs up to four divisions (one is skipped when its metric is undefined)
// on a shared bit-serial divider. A two-word queue sits between the front decoder and the
// back engine.
module confusion_matrix_metrics_core (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire cmm_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output cmm_pkg::rsp_type rsp_data
);
   logic cmd_valid, cmd_ready;
   cmm_pkg::cmd_type cmd_data;

   cmm_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd_data(cmd_data)
   );

   cmm_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd_data(cmd_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

[rtl/cmm_front.sv]
`default_nettype none
module cmm_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire cmm_pkg::req_type req_data,
   output logic cmd_valid,
   input wire logic cmd_ready,
   output cmm_pkg::cmd_type cmd_data
);
   // two-entry queue
   cmm_pkg::cmd_type q_ff [2];
   cmm_pkg::cmd_type q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic push, pop;
   logic [4:0] row;

   assign req_ready = cnt_ff != 2'd2;
   assign push = req_valid && req_ready;
   assign cmd_valid = cnt_ff != 2'd0;
   assign pop = cmd_valid && cmd_ready;
   assign cmd_data = q_ff[rp_ff];

   // classify
   always_comb begin
      row = req_data.true_unknown ? 5'(cmm_pkg::Classes) : {1'b0, req_data.true_class};
      q_in = '0;
      q_in.rcls = req_data.report_class;
      q_in.cell_idx = cmm_pkg::CellBits'(row) * cmm_pkg::CellBits'(cmm_pkg::Classes)
         + cmm_pkg::CellBits'(req_data.predicted_class);
      q_in.inc = (req_data.mode == cmm_pkg::ModeRecord) ? 32'd1 : req_data.add_count;
      if (req_data.mode == cmm_pkg::ModeRecord || req_data.mode == cmm_pkg::ModeAdd) begin
         if (req_data.mode == cmm_pkg::ModeRecord && !req_data.predicted_present)
            q_in.error = 1'b1;
         else
            q_in.is_update = 1'b1;
      end else if (req_data.mode == cmm_pkg::ModeReport) begin
         q_in.is_report = 1'b1;
      end
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= q_in;
      if (reset) begin
         cnt_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end

   `include "confusion_matrix_metrics_core_macros.svh"
   `CMM_ASSERT_IMP(a_no_over, clock, reset, push, cnt_ff != 2'd2)
   `CMM_ASSERT_IMP(a_no_under, clock, reset, pop, cnt_ff != 2'd0)
   `CMM_ASSERT_NXT(a_cnt, clock, reset, push && !pop, cnt_ff != 2'd0)
endmodule
`default_nettype wire

[rtl/cmm_div.sv]
`default_nettype none
module cmm_div (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [49:0] num,
   input wire logic [33:0] den,
   output logic busy,
   output logic [16:0] quot
);
   // restoring divider, one bit a cycle, quotient fits 17 bits
   logic [33:0] rem_ff, rem_in;
   logic [49:0] n_ff, n_in;
   logic [33:0] d_ff;
   logic [16:0] q_ff, q_in;
   logic [5:0] i_ff, i_in;
   logic [34:0] t;

   assign busy = i_ff != 6'd0;
   assign quot = q_ff;

   always_comb begin
      rem_in = rem_ff; n_in = n_ff; q_in = q_ff; i_in = i_ff;
      t = {rem_ff, n_ff[49]};
      if (start) begin
         rem_in = '0; n_in = num; q_in = '0; i_in = 6'd50;
      end else if (busy) begin
         n_in = {n_ff[48:0], 1'b0};
         if (t >= {1'b0, d_ff}) begin
            rem_in = 34'(t - {1'b0, d_ff});
            q_in = {q_ff[15:0], 1'b1};
         end else begin
            rem_in = t[33:0];
            q_in = {q_ff[15:0], 1'b0};
         end
         i_in = i_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; n_ff <= n_in; q_ff <= q_in;
      if (start) d_ff <= den;
      if (reset) i_ff <= '0;
      else i_ff <= i_in;
   end
endmodule
`default_nettype wire

[rtl/cmm_back.sv]
`default_nettype none
module cmm_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic cmd_valid,
   output logic cmd_ready,
   input wire cmm_pkg::cmd_type cmd_data,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output cmm_pkg::rsp_type rsp_data
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_UPD_RD, S_UPD_WR, S_WALK, S_WALK_LAST,
      S_DIVP, S_DIVR, S_DIVF, S_DIVS, S_FIN, S_OUT
   } state_type;

   localparam int CB = cmm_pkg::CellBits;

   state_type st_ff;
   logic [31:0] mem [cmm_pkg::Cells];
   logic [31:0] rd_ff;
   logic [CB-1:0] addr_ff;
   logic [CB:0] walk_ff;
   logic [4:0] row_ff;
   logic [3:0] col_ff;
   cmm_pkg::cmd_type cmd_ff;
   cmm_pkg::rsp_type out_ff;
   logic rd_act_ff;
   logic [4:0] rrow_ff;
   logic [3:0] rcol_ff;
   logic [31:0] tp_ff, fp_ff, tn_ff, fn_ff;
   logic [16:0] p_ff, r_ff, f_ff;
   logic [4:0] vm_ff;
   logic we;
   logic [CB-1:0] wa;
   logic [31:0] wd;
   logic [CB-1:0] ra;
   logic [32:0] upd_sum;
   logic div_start, div_busy;
   logic [49:0] div_num;
   logic [33:0] div_den;
   logic [16:0] div_q;
   logic [32:0] dp, dr, df;
   logic [17:0] prs;
   logic [33:0] fs_num;
   logic [4:0] rc5;

   cmm_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .busy(div_busy), .quot(div_q)
   );

   assign cmd_ready = st_ff == S_IDLE;
   assign rsp_valid = st_ff == S_OUT;
   assign rsp_data = out_ff;
   assign upd_sum = {1'b0, rd_ff} + {1'b0, cmd_ff.inc};
   assign dp = {1'b0, tp_ff} + {1'b0, fp_ff};
   assign dr = {1'b0, tp_ff} + {1'b0, fn_ff};
   assign df = {1'b0, fp_ff} + {1'b0, tn_ff};
   assign prs = {1'b0, p_ff} + {1'b0, r_ff};
   assign fs_num = 34'(p_ff) * 34'(r_ff);
   assign rc5 = {1'b0, cmd_ff.rcls};

   // memory read select: new word, held update cell, or walk pointer
   always_comb begin
      if (st_ff == S_IDLE) ra = cmd_data.cell_idx;
      else if (st_ff == S_UPD_RD) ra = addr_ff;
      else ra = walk_ff[CB-1:0];
   end

   // memory write select
   always_comb begin
      we = 1'b0; wa = addr_ff; wd = '0;
      if (st_ff == S_CLEAR) begin
         we = 1'b1; wa = walk_ff[CB-1:0];
      end else if (st_ff == S_UPD_WR) begin
         we = 1'b1; wd = upd_sum[32] ? 32'hFFFF_FFFF : upd_sum[31:0];
      end
   end

   // divider operand select, one start per metric state
   always_comb begin
      div_start = 1'b0; div_num = '0; div_den = '0;
      unique case (st_ff)
         S_DIVP: begin
            div_start = !div_busy && !rd_act_ff && dp != 0;
            div_num = {tp_ff, 16'd0} + 50'(dp >> 1); div_den = 34'(dp);
         end
         S_DIVR: begin
            div_start = !div_busy && !rd_act_ff && dr != 0;
            div_num = {tp_ff, 16'd0} + 50'(dr >> 1); div_den = 34'(dr);
         end
         S_DIVF: begin
            div_start = !div_busy && !rd_act_ff && df != 0;
            div_num = {fp_ff, 16'd0} + 50'(df >> 1); div_den = 34'(df);
         end
         S_DIVS: begin
            div_start = !div_busy && !rd_act_ff && vm_ff[1:0] == 2'b11 && prs != 0;
            div_num = 50'({fs_num, 1'b0}) + 50'(prs >> 1); div_den = 34'(prs);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
      if (reset) begin
         st_ff <= S_CLEAR;
         walk_ff <= '0;
         rd_act_ff <= 1'b0;
      end else begin
         unique case (st_ff)
            S_CLEAR: begin
               walk_ff <= walk_ff + 1'b1;
               if (walk_ff == (CB + 1)'(cmm_pkg::Cells - 1)) st_ff <= S_IDLE;
            end
            S_IDLE: if (cmd_valid) begin
               cmd_ff <= cmd_data;
               addr_ff <= cmd_data.cell_idx;
               out_ff <= '{error: cmd_data.error, default: '0};
               tp_ff <= '0; fp_ff <= '0; tn_ff <= '0; fn_ff <= '0;
               p_ff <= '0; r_ff <= '0; f_ff <= '0; vm_ff <= '0;
               walk_ff <= '0; row_ff <= '0; col_ff <= '0; rd_act_ff <= 1'b0;
               if (cmd_data.is_update) st_ff <= S_UPD_RD;
               else if (cmd_data.is_report) st_ff <= S_WALK;
               else st_ff <= S_OUT;
            end
            S_UPD_RD: st_ff <= S_UPD_WR;
            S_UPD_WR: st_ff <= S_OUT;
            S_WALK, S_WALK_LAST: begin
               // accumulate the cell read last cycle
               if (rd_act_ff) begin
                  if (rrow_ff == rc5 && rcol_ff == cmd_ff.rcls) tp_ff <= rd_ff;
                  else if (rrow_ff == rc5) fn_ff <= cmm_pkg::sat_add(fn_ff, rd_ff);
                  else if (rcol_ff == cmd_ff.rcls) fp_ff <= cmm_pkg::sat_add(fp_ff, rd_ff);
                  else tn_ff <= cmm_pkg::sat_add(tn_ff, rd_ff);
               end
               rrow_ff <= row_ff; rcol_ff <= col_ff;
               rd_act_ff <= st_ff == S_WALK;
               if (st_ff == S_WALK_LAST) st_ff <= S_DIVP;
               else begin
                  walk_ff <= walk_ff + 1'b1;
                  col_ff <= col_ff + 4'd1;
                  if (col_ff == 4'(cmm_pkg::Classes - 1)) row_ff <= row_ff + 5'd1;
                  if (walk_ff == (CB + 1)'(cmm_pkg::Cells - 1)) st_ff <= S_WALK_LAST;
               end
            end
            S_DIVP, S_DIVR, S_DIVF, S_DIVS: begin
               if (div_start) ;
               else if (!div_busy) begin
                  // divider idle: either result just ready or metric undefined
                  unique case (st_ff)
                     S_DIVP: begin
                        if (dp != 0 && rd_act_ff) begin p_ff <= div_q; vm_ff[0] <= 1'b1; end
                        st_ff <= S_DIVR;
                     end
                     S_DIVR: begin
                        if (dr != 0 && rd_act_ff) begin r_ff <= div_q; vm_ff[1] <= 1'b1; end
                        st_ff <= S_DIVF;
                     end
                     S_DIVF: begin
                        if (df != 0 && rd_act_ff) begin f_ff <= div_q; vm_ff[2] <= 1'b1; end
                        st_ff <= S_DIVS;
                     end
                     default: begin
                        if (vm_ff[1:0] == 2'b11 && prs != 0 && rd_act_ff) begin
                           out_ff.fscore_q16 <= div_q; vm_ff[3] <= 1'b1;
                        end
                        st_ff <= S_FIN;
                     end
                  endcase
               end
               // rd_act_ff marks that the divide for this state has run
               if (div_start) rd_act_ff <= 1'b1;
               else if (!div_busy) rd_act_ff <= 1'b0;
            end
            S_FIN: begin
               out_ff <= '{true_pos: tp_ff, false_pos: fp_ff, true_neg: tn_ff,
                  false_neg: fn_ff, precision_q16: p_ff, recall_q16: r_ff,
                  fpr_q16: f_ff, fscore_q16: out_ff.fscore_q16,
                  auc_q16: (vm_ff[1] && vm_ff[2]) ?
                     17'((18'd65537 + 18'(r_ff) - 18'(f_ff)) >> 1) : 17'd0,
                  valid_mask: {vm_ff[1] & vm_ff[2], vm_ff[3:0]},
                  error: out_ff.error};
               st_ff <= S_OUT;
            end
            S_OUT: if (rsp_ready) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   `include "confusion_matrix_metrics_core_macros.svh"
   `CMM_ASSERT_IMP(a_one_owner, clock, reset, cmd_ready, !rsp_valid)
   `CMM_ASSERT_NXT(a_upd, clock, reset, st_ff == S_UPD_RD, st_ff == S_UPD_WR)
   `CMM_ASSERT_IMP(a_div_idle, clock, reset, div_start, !div_busy)
endmodule
`default_nettype wire
